/* hw/rtl/smie_pkg.sv */
// smie_pkg: opcodes, status codes, state types and request struct for the
// stack machine integer executor. No dependencies.
`timescale 1ns / 1ps

package smie_pkg;

    typedef enum logic [5:0] {
        OP_ADD     = 6'd0,
        OP_SUB     = 6'd1,
        OP_MUL     = 6'd2,
        OP_DIV     = 6'd3,
        OP_AND     = 6'd4,
        OP_OR      = 6'd5,
        OP_XOR     = 6'd6,
        OP_MOD     = 6'd7,
        OP_EQ      = 6'd8,
        OP_NE      = 6'd9,
        OP_GT      = 6'd10,
        OP_GE      = 6'd11,
        OP_LT      = 6'd12,
        OP_LE      = 6'd13,
        OP_INC     = 6'd14,
        OP_DEC     = 6'd15,
        OP_NEG     = 6'd16,
        OP_LOAD    = 6'd17,
        OP_LOADCP  = 6'd18,
        OP_STORE   = 6'd19,
        OP_STORECP = 6'd20,
        OP_CLRL    = 6'd21,
        OP_CLRE    = 6'd22,
        OP_POP     = 6'd23,
        OP_PUSH    = 6'd24,
        OP_DUP     = 6'd25,
        OP_SWAP    = 6'd26,
        OP_BR      = 6'd27,
        OP_BRIF    = 6'd28,
        OP_NOP     = 6'd29,
        OP_PRINTI  = 6'd30,
        OP_PRINTC  = 6'd31,
        OP_HALT    = 6'd32
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_ZDIV  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEC,
        S_RD1,
        S_RD2,
        S_EXEC,
        S_WAIT,
        S_WR2,
        S_DONE
    } sm_state_t;

    typedef enum logic [1:0] {
        M_IDLE,
        M_RUN,
        M_FIN
    } md_state_t;

    typedef enum logic [1:0] {
        MD_MUL,
        MD_SDIV,
        MD_UMOD
    } md_kind_t;

    typedef struct packed {
        logic     start;
        md_kind_t kind;
    } md_req_t;

endpackage

/* hw/rtl/smie_alu.sv */
// smie_alu: combinational add/sub/logic/compare/inc/dec/neg unit.
// Depends on smie_pkg.
`timescale 1ns / 1ps

module smie_alu (
    input  smie_pkg::op_t op,
    input  logic [63:0]   a,      // second entry
    input  logic [63:0]   b,      // top entry
    output logic [63:0]   result
);
    import smie_pkg::*;

    logic lt_s;
    logic eq;

    assign lt_s = $signed(a) < $signed(b);
    assign eq   = (a == b);

    // unary ops work on the top entry
    always_comb
    begin
        result = 64'd0;
        case (op)
            OP_ADD: result = a + b;
            OP_SUB: result = a - b;
            OP_AND: result = a & b;
            OP_OR:  result = a | b;
            OP_XOR: result = a ^ b;
            OP_EQ:  result = {63'd0, eq};
            OP_NE:  result = {63'd0, !eq};
            OP_GT:  result = {63'd0, !lt_s && !eq};
            OP_GE:  result = {63'd0, !lt_s};
            OP_LT:  result = {63'd0, lt_s};
            OP_LE:  result = {63'd0, lt_s || eq};
            OP_INC: result = b + 64'd1;
            OP_DEC: result = b - 64'd1;
            OP_NEG: result = 64'd0 - b;
            default: result = 64'd0;
        endcase
    end

endmodule

/* hw/rtl/smie_muldiv.sv */
// smie_muldiv: bit-serial multiplier (low 64 bits) and restoring divider,
// one bit per cycle. Depends on smie_pkg.
`timescale 1ns / 1ps

module smie_muldiv (
    input  logic             clk,
    input  logic             rst_n,
    input  smie_pkg::md_req_t req,
    input  logic [63:0]      a,     // multiplicand / dividend
    input  logic [63:0]      b,     // multiplier / divisor
    output logic             done,
    output logic [63:0]      result
);
    import smie_pkg::*;

    md_state_t   state_reg, state_next;
    md_kind_t    kind_reg, kind_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [63:0] acc_reg, acc_next;     // product or remainder
    logic [63:0] x_reg, x_next;         // multiplicand or dividend/quotient
    logic [63:0] y_reg, y_next;         // multiplier or divisor
    logic        neg_reg, neg_next;
    logic [64:0] trial;
    logic [64:0] diff;

    assign trial = {acc_reg, x_reg[63]};
    assign diff  = trial - {1'b0, y_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        cnt_reg  <= cnt_next;
        acc_reg  <= acc_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        neg_reg  <= neg_next;
    end

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        neg_next   = neg_reg;
        done       = 1'b0;
        result     = acc_reg;
        unique case (state_reg)
            M_IDLE:
            begin
                if (req.start)
                begin
                    kind_next  = req.kind;
                    cnt_next   = 7'd64;
                    acc_next   = 64'd0;
                    neg_next   = 1'b0;
                    x_next     = a;
                    y_next     = b;
                    if (req.kind == MD_SDIV)
                    begin
                        x_next   = a[63] ? 64'd0 - a : a;
                        y_next   = b[63] ? 64'd0 - b : b;
                        neg_next = a[63] ^ b[63];
                    end
                    state_next = M_RUN;
                end
            end
            M_RUN:
            begin
                if (kind_reg == MD_MUL)
                begin
                    // shift-add
                    if (y_reg[0])
                    begin
                        acc_next = acc_reg + x_reg;
                    end
                    x_next = {x_reg[62:0], 1'b0};
                    y_next = {1'b0, y_reg[63:1]};
                end
                else
                begin
                    // restoring step
                    if (!diff[64])
                    begin
                        acc_next = diff[63:0];
                        x_next   = {x_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        acc_next = trial[63:0];
                        x_next   = {x_reg[62:0], 1'b0};
                    end
                end
                cnt_next = cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    state_next = M_FIN;
                end
            end
            M_FIN:
            begin
                done = 1'b1;
                unique case (kind_reg)
                    MD_MUL:  result = acc_reg;
                    MD_SDIV: result = neg_reg ? 64'd0 - x_reg : x_reg;
                    default: result = acc_reg;
                endcase
                state_next = M_IDLE;
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/stack_machine_integer_executor_unit.sv */
// stack_machine_integer_executor_unit: sequencer, evaluation and local stack
// memories. Uses smie_pkg, smie_alu and smie_muldiv.
`timescale 1ns / 1ps
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+----------------------
//  command  | opcode, immediate                       | start & !busy
//  result   | status, jump_taken, jump_target,        | done, one cycle
//           | emit_valid, emit_is_char, emit_value,   |
//           | halted                                  |
//
//  A transaction runs decode, one or two stack reads and execute if it reads
//  a stack, and done; swap writes twice; mul, div and mod wait on muldiv.
//  Each stack memory has one registered read port, so operands come one per
//  cycle. busy is high whenever the sequencer is not idle, done included.
//  Reset clears both counts and the halt flag; memory contents are kept.
//  The receiver cannot stall: done is a single-cycle strobe.

module stack_machine_integer_executor_unit #(
    parameter int EVAL_DEPTH  = 256,
    parameter int LOCAL_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [5:0]  opcode,
    input  logic [63:0] immediate,
    output logic        done,
    output logic [1:0]  status,
    output logic        jump_taken,
    output logic [63:0] jump_target,
    output logic        emit_valid,
    output logic        emit_is_char,
    output logic [63:0] emit_value,
    output logic        halted
);
    import smie_pkg::*;

    localparam int EAW = $clog2(EVAL_DEPTH);
    localparam int ECW = $clog2(EVAL_DEPTH + 1);
    localparam int LAW = $clog2(LOCAL_DEPTH);
    localparam int LCW = $clog2(LOCAL_DEPTH + 1);

    sm_state_t      state_reg, state_next;
    op_t            op_reg, op_next;
    logic [63:0]    imm_reg, imm_next;
    logic [ECW-1:0] ec_reg, ec_next;
    logic [LCW-1:0] lc_reg, lc_next;
    logic           halt_reg, halt_next;
    logic [63:0]    top_reg, top_next;
    logic [63:0]    nxt_reg, nxt_next;

    status_t        st_reg, st_next;
    logic           jt_reg, jt_next;
    logic [63:0]    jtgt_reg, jtgt_next;
    logic           ev_reg, ev_next;
    logic           ech_reg, ech_next;
    logic [63:0]    evl_reg, evl_next;

    // memories
    logic [63:0]    eval_mem [EVAL_DEPTH];
    logic [63:0]    local_mem [LOCAL_DEPTH];
    logic [63:0]    e_rdata_reg;
    logic [63:0]    l_rdata_reg;
    logic           e_re, e_we, l_re, l_we;
    logic [EAW-1:0] e_raddr, e_waddr;
    logic [LAW-1:0] l_raddr, l_waddr;
    logic [63:0]    e_wdata, l_wdata;

    logic [ECW-1:0] ec_m1, ec_m2, ec_m3;
    logic [LCW-1:0] lc_m1;
    logic           e_lt1, e_lt2, e_full, l_lt1, l_full;
    status_t        chk;
    logic           need2;

    md_req_t        md_req;
    logic           md_done;
    logic [63:0]    md_result;
    logic [63:0]    alu_result;

    assign ec_m1  = ec_reg - ECW'(1);
    assign ec_m2  = ec_reg - ECW'(2);
    assign ec_m3  = ec_reg - ECW'(3);
    assign lc_m1  = lc_reg - LCW'(1);
    assign e_lt1  = (ec_reg == ECW'(0));
    assign e_lt2  = (ec_reg < ECW'(2));
    assign e_full = (ec_reg >= ECW'(EVAL_DEPTH));
    assign l_lt1  = (lc_reg == LCW'(0));
    assign l_full = (lc_reg >= LCW'(LOCAL_DEPTH));

    smie_alu u_alu (
        .op     (op_reg),
        .a      (nxt_reg),
        .b      (top_reg),
        .result (alu_result)
    );

    smie_muldiv u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (md_req),
        .a      (nxt_reg),
        .b      (top_reg),
        .done   (md_done),
        .result (md_result)
    );

    // stack memories: one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (e_we)
        begin
            eval_mem[e_waddr] <= e_wdata;
        end
        if (e_re)
        begin
            e_rdata_reg <= eval_mem[e_raddr];
        end
        if (l_we)
        begin
            local_mem[l_waddr] <= l_wdata;
        end
        if (l_re)
        begin
            l_rdata_reg <= local_mem[l_raddr];
        end
    end

    // depth checks: underflow before overflow
    always_comb
    begin
        chk   = ST_OK;
        need2 = 1'b0;
        case (op_reg)
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_AND, OP_OR, OP_XOR, OP_MOD:
            begin
                need2 = 1'b1;
                if (e_lt2) chk = ST_UNDER;
            end
            OP_EQ, OP_NE, OP_GT, OP_GE, OP_LT, OP_LE:
            begin
                need2 = 1'b1;
                if (e_lt2) chk = ST_UNDER;
                else if (e_full) chk = ST_OVER;
            end
            OP_SWAP, OP_BRIF:
            begin
                need2 = 1'b1;
                if (e_lt2) chk = ST_UNDER;
            end
            OP_INC, OP_DEC, OP_NEG, OP_POP, OP_BR, OP_PRINTI, OP_PRINTC:
            begin
                if (e_lt1) chk = ST_UNDER;
            end
            OP_LOAD, OP_LOADCP:
            begin
                if (l_lt1) chk = ST_UNDER;
                else if (e_full) chk = ST_OVER;
            end
            OP_STORE, OP_STORECP:
            begin
                if (e_lt1) chk = ST_UNDER;
                else if (l_full) chk = ST_OVER;
            end
            OP_PUSH:
            begin
                if (e_full) chk = ST_OVER;
            end
            OP_DUP:
            begin
                if (e_lt1) chk = ST_UNDER;
                else if (e_full) chk = ST_OVER;
            end
            default:
            begin
                chk = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ec_reg    <= '0;
            lc_reg    <= '0;
            halt_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ec_reg    <= ec_next;
            lc_reg    <= lc_next;
            halt_reg  <= halt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        imm_reg  <= imm_next;
        top_reg  <= top_next;
        nxt_reg  <= nxt_next;
        st_reg   <= st_next;
        jt_reg   <= jt_next;
        jtgt_reg <= jtgt_next;
        ev_reg   <= ev_next;
        ech_reg  <= ech_next;
        evl_reg  <= evl_next;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        imm_next   = imm_reg;
        ec_next    = ec_reg;
        lc_next    = lc_reg;
        halt_next  = halt_reg;
        top_next   = top_reg;
        nxt_next   = nxt_reg;
        st_next    = st_reg;
        jt_next    = jt_reg;
        jtgt_next  = jtgt_reg;
        ev_next    = ev_reg;
        ech_next   = ech_reg;
        evl_next   = evl_reg;
        e_re       = 1'b0;
        e_we       = 1'b0;
        l_re       = 1'b0;
        l_we       = 1'b0;
        e_raddr    = ec_m1[EAW-1:0];
        e_waddr    = ec_reg[EAW-1:0];
        e_wdata    = top_reg;
        l_raddr    = lc_m1[LAW-1:0];
        l_waddr    = lc_reg[LAW-1:0];
        l_wdata    = top_reg;
        md_req     = '{start: 1'b0, kind: MD_MUL};

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = op_t'(opcode);
                    imm_next   = immediate;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                st_next    = ST_OK;
                jt_next    = 1'b0;
                jtgt_next  = 64'd0;
                ev_next    = 1'b0;
                ech_next   = 1'b0;
                evl_next   = 64'd0;
                state_next = S_DONE;
                if (halt_reg)
                begin
                    state_next = S_DONE;
                end
                else if (chk != ST_OK)
                begin
                    st_next = chk;
                end
                else
                begin
                    case (op_reg)
                        OP_CLRL: lc_next = '0;
                        OP_CLRE: ec_next = '0;
                        OP_POP:  ec_next = ec_m1;
                        OP_PUSH:
                        begin
                            e_we    = 1'b1;
                            e_wdata = imm_reg;
                            ec_next = ec_reg + ECW'(1);
                        end
                        OP_HALT: halt_next = 1'b1;
                        OP_LOAD, OP_LOADCP:
                        begin
                            l_re       = 1'b1;
                            state_next = S_RD1;
                        end
                        OP_NOP:
                        begin
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            // every remaining defined opcode reads the top
                            if (op_reg < OP_NOP || op_reg == OP_PRINTI
                                || op_reg == OP_PRINTC)
                            begin
                                e_re       = 1'b1;
                                state_next = S_RD1;
                            end
                        end
                    endcase
                end
            end
            S_RD1:
            begin
                if (op_reg == OP_LOAD || op_reg == OP_LOADCP)
                begin
                    top_next = l_rdata_reg;
                end
                else
                begin
                    top_next = e_rdata_reg;
                end
                if (need2)
                begin
                    e_re       = 1'b1;
                    e_raddr    = ec_m2[EAW-1:0];
                    state_next = S_RD2;
                end
                else
                begin
                    state_next = S_EXEC;
                end
            end
            S_RD2:
            begin
                nxt_next   = e_rdata_reg;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                case (op_reg)
                    OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR:
                    begin
                        e_we    = 1'b1;
                        e_waddr = ec_m2[EAW-1:0];
                        e_wdata = alu_result;
                        ec_next = ec_m1;
                    end
                    OP_MUL:
                    begin
                        md_req     = '{start: 1'b1, kind: MD_MUL};
                        state_next = S_WAIT;
                    end
                    OP_DIV, OP_MOD:
                    begin
                        if (top_reg == 64'd0)
                        begin
                            st_next = ST_ZDIV;
                        end
                        else
                        begin
                            md_req = '{start: 1'b1,
                                       kind: (op_reg == OP_DIV) ? MD_SDIV : MD_UMOD};
                            state_next = S_WAIT;
                        end
                    end
                    OP_EQ, OP_NE, OP_GT, OP_GE, OP_LT, OP_LE:
                    begin
                        e_we    = 1'b1;
                        e_wdata = alu_result;
                        ec_next = ec_reg + ECW'(1);
                    end
                    OP_INC, OP_DEC, OP_NEG:
                    begin
                        e_we    = 1'b1;
                        e_waddr = ec_m1[EAW-1:0];
                        e_wdata = alu_result;
                    end
                    OP_LOAD, OP_LOADCP:
                    begin
                        e_we    = 1'b1;
                        ec_next = ec_reg + ECW'(1);
                        if (op_reg == OP_LOAD) lc_next = lc_m1;
                    end
                    OP_STORE, OP_STORECP:
                    begin
                        l_we    = 1'b1;
                        lc_next = lc_reg + LCW'(1);
                        if (op_reg == OP_STORE) ec_next = ec_m1;
                    end
                    OP_DUP:
                    begin
                        e_we    = 1'b1;
                        ec_next = ec_reg + ECW'(1);
                    end
                    OP_SWAP:
                    begin
                        e_we       = 1'b1;
                        e_waddr    = ec_m2[EAW-1:0];
                        state_next = S_WR2;
                    end
                    OP_BR:
                    begin
                        jt_next   = 1'b1;
                        jtgt_next = top_reg;
                        ec_next   = ec_m1;
                    end
                    OP_BRIF:
                    begin
                        ec_next = ec_m2;
                        if (nxt_reg != 64'd0)
                        begin
                            jt_next   = 1'b1;
                            jtgt_next = top_reg;
                            if (ec_m2 != ECW'(0)) ec_next = ec_m3;
                        end
                    end
                    OP_PRINTI, OP_PRINTC:
                    begin
                        ev_next  = 1'b1;
                        ech_next = (op_reg == OP_PRINTC);
                        evl_next = (op_reg == OP_PRINTC) ? {56'd0, top_reg[7:0]}
                                                         : top_reg;
                        ec_next  = ec_m1;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_WAIT:
            begin
                if (md_done)
                begin
                    e_we       = 1'b1;
                    e_waddr    = ec_m2[EAW-1:0];
                    e_wdata    = md_result;
                    ec_next    = ec_m1;
                    state_next = S_DONE;
                end
            end
            S_WR2:
            begin
                // second half of swap
                e_we       = 1'b1;
                e_waddr    = ec_m1[EAW-1:0];
                e_wdata    = nxt_reg;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result ports
    assign busy         = (state_reg != S_IDLE);
    assign done         = (state_reg == S_DONE);
    assign status       = st_reg;
    assign jump_taken   = jt_reg;
    assign jump_target  = jtgt_reg;
    assign emit_valid   = ev_reg;
    assign emit_is_char = ech_reg;
    assign emit_value   = evl_reg;
    assign halted       = halt_reg;

endmodule
